// ----- design/motor_speed_pi_feedforward_core_defines.svh -----
// Assertion macros shared by the speed controller RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MOTOR_SPEED_PI_FEEDFORWARD_CORE_DEFINES_SVH
`define MOTOR_SPEED_PI_FEEDFORWARD_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSP_ASSERT_COND(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
`define MSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSP_ASSERT_COND(lbl, cond, msg)
`define MSP_ASSERT_IMPL(lbl, ante, cons, msg)
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/msp_pkg.sv -----
// Types, constants and the microcode program of the motor speed controller.
// Used by the interfaces, the sequencer, the datapath and the top level.
package msp_pkg;

  // Field and register widths.
  localparam int CNT_W      = 16;
  localparam int DUTY_W     = 10;
  localparam int GAIN_W     = 16;
  localparam int RPC_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths.
  localparam int MUL_A_W = 39;
  localparam int PROD_W  = 64;
  localparam int MEAS_W  = 40;
  localparam int TGT_W   = 33;
  localparam int DIF_W   = 42;
  localparam int ERR_W   = 38;
  localparam int DIFF_W  = 39;
  localparam int ACC_W   = 58;
  localparam int T_W     = 46;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RPM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_TIMES_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_OVER_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_COUNT   = 3'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GEAR_RATIO_RST = 16'd33536;
  localparam logic [GAIN_W-1:0] KP_GAIN_RST    = 16'd1966;
  localparam logic [GAIN_W-1:0] KI_RST         = 16'd131;
  localparam logic [GAIN_W-1:0] KD_RST         = 16'd0;
  localparam logic [GAIN_W-1:0] FF_GAIN_RST    = 16'd7449;
  localparam logic [RPC_W-1:0]  RPC_RST        = 24'd3072000;

  // Program addresses.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MEAS_MUL = 4'd1;
  localparam logic [STEP_W-1:0] STEP_TGT_MUL  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ERR      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_KI_MUL   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_INT_ADD  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INT_SAT  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_KD_MUL   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_KD_ADD   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DRV_SUM  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DRV_SAT  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_OUTPUT   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_LAST     = STEP_CLEAR;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CNT_RPC,
    MUL_TGT_GEAR,
    MUL_KI_ERR,
    MUL_FF_TGT,
    MUL_KP_ERR,
    MUL_KD_DIFF
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MEAS,
    OP_ERR,
    OP_DIFF,
    OP_INT_ADD,
    OP_INT_SAT,
    OP_DRV_SUM,
    OP_DRV_SAT,
    OP_OUTPUT,
    OP_CLEAR
  } reg_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_IF_OFF,
    JMP_ALWAYS,
    JMP_WAIT_OUT
  } jmp_op_t;

  typedef struct packed {
    mul_sel_t            mul_sel;
    acc_op_t             acc_op;
    reg_op_t             reg_op;
    jmp_op_t             jmp_op;
    logic [STEP_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic enable;
    logic out_free;
  } status_t;

  // Control store. Products are registered out of the shared multiplier,
  // so a step that uses a product takes the one whose operands were
  // selected by the step before it.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, reg_op: OP_NOP,
          jmp_op: JMP_NEXT, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.jmp_op = JMP_WAIT_IN;
      end
      STEP_MEAS_MUL: begin
        w.mul_sel = MUL_CNT_RPC;
        w.jmp_op  = JMP_IF_OFF;
        w.target  = STEP_CLEAR;
      end
      STEP_TGT_MUL: begin
        w.mul_sel = MUL_TGT_GEAR;
        w.reg_op  = OP_MEAS;
      end
      STEP_ERR: begin
        w.reg_op = OP_ERR;
      end
      STEP_KI_MUL: begin
        w.mul_sel = MUL_KI_ERR;
        w.reg_op  = OP_DIFF;
      end
      STEP_INT_ADD: begin
        w.mul_sel = MUL_FF_TGT;
        w.reg_op  = OP_INT_ADD;
      end
      STEP_INT_SAT: begin
        w.mul_sel = MUL_KP_ERR;
        w.reg_op  = OP_INT_SAT;
        w.acc_op  = ACC_LOAD;
      end
      STEP_KD_MUL: begin
        w.mul_sel = MUL_KD_DIFF;
        w.acc_op  = ACC_ADD;
      end
      STEP_KD_ADD: begin
        w.acc_op = ACC_ADD;
      end
      STEP_DRV_SUM: begin
        w.reg_op = OP_DRV_SUM;
      end
      STEP_DRV_SAT: begin
        w.reg_op = OP_DRV_SAT;
      end
      STEP_OUTPUT: begin
        w.reg_op = OP_OUTPUT;
        w.jmp_op = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      STEP_CLEAR: begin
        w.reg_op = OP_CLEAR;
        w.jmp_op = JMP_ALWAYS;
        w.target = STEP_OUTPUT;
      end
      default: begin
        w.jmp_op = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/msp_if.sv -----
// Stream interfaces for the encoder tick input and the bridge duty result.
// Widths come from msp_pkg.
interface msp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [msp_pkg::CNT_W-1:0]  encoder_count;

  modport source (output valid, output encoder_count, input ready);
  modport sink (input valid, input encoder_count, output ready);
endinterface

interface msp_out_if;
  logic                        valid;
  logic                        ready;
  logic [msp_pkg::DUTY_W-1:0]  duty_forward;
  logic [msp_pkg::DUTY_W-1:0]  duty_reverse;

  modport source (output valid, output duty_forward, output duty_reverse, input ready);
  modport sink (input valid, input duty_forward, input duty_reverse, output ready);
endinterface

// ----- design/msp_sequencer.sv -----
// Step counter and jump logic that walks the microcode program in msp_pkg.
// Depends on msp_pkg and the assertion macros header.
`include "motor_speed_pi_feedforward_core_defines.svh"

module msp_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  msp_pkg::status_t  st,
  output msp_pkg::uword_t   uw,
  output logic              in_ready
);

  logic [msp_pkg::STEP_W-1:0] step_r;
  logic [msp_pkg::STEP_W-1:0] step_nxt;
  logic [msp_pkg::STEP_W-1:0] step_inc;

  assign uw       = msp_pkg::ucode(step_r);
  assign step_inc = step_r + msp_pkg::STEP_W'(1);
  assign in_ready = (uw.jmp_op == msp_pkg::JMP_WAIT_IN);

  always_comb begin
    unique case (uw.jmp_op)
      msp_pkg::JMP_NEXT:     step_nxt = step_inc;
      msp_pkg::JMP_WAIT_IN:  step_nxt = st.in_valid ? step_inc : step_r;
      msp_pkg::JMP_IF_OFF:   step_nxt = st.enable ? step_inc : uw.target;
      msp_pkg::JMP_ALWAYS:   step_nxt = uw.target;
      msp_pkg::JMP_WAIT_OUT: step_nxt = st.out_free ? uw.target : step_r;
      default:               step_nxt = msp_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= msp_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  `MSP_ASSERT_NEXT(a_beat_starts_run, in_ready && st.in_valid, step_r == msp_pkg::STEP_MEAS_MUL, "input beat did not start the program")
  `MSP_ASSERT_NEXT(a_off_goes_clear, (step_r == msp_pkg::STEP_MEAS_MUL) && !st.enable, step_r == msp_pkg::STEP_CLEAR, "disabled drive did not branch to the clear step")
  `MSP_ASSERT_COND(a_step_in_program, step_r <= msp_pkg::STEP_LAST, "step counter left the program")

endmodule

// ----- design/msp_datapath.sv -----
// Datapath of the speed controller: configuration registers, one shared
// multiplier, the Q32 accumulator, loop state and the result register.
// Depends on msp_pkg and the assertion macros header.
`include "motor_speed_pi_feedforward_core_defines.svh"

module msp_datapath #(
  parameter int DUTY_MAX    = 1023,
  parameter int COUNT_LIMIT = 30000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msp_pkg::uword_t                     uw,
  input  logic                                in_ready,
  input  logic                                in_valid,
  input  logic signed [msp_pkg::CNT_W-1:0]    encoder_count,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [msp_pkg::DUTY_W-1:0]          duty_forward,
  output logic [msp_pkg::DUTY_W-1:0]          duty_reverse,
  input  logic                                cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output msp_pkg::status_t                    st
);

  localparam int LIM_W = $clog2(DUTY_MAX + 1) + 16;
  localparam int INT_W = LIM_W + 1;
  localparam int DS_W  = INT_W + 1;

  localparam logic signed [msp_pkg::CNT_W-1:0] CNT_HI = msp_pkg::CNT_W'(COUNT_LIMIT);
  localparam logic signed [msp_pkg::CNT_W-1:0] CNT_LO = -CNT_HI;
  localparam logic signed [msp_pkg::T_W-1:0]   LIM_T  = msp_pkg::T_W'(DUTY_MAX) << 16;
  localparam logic signed [msp_pkg::T_W-1:0]   NLIM_T = -LIM_T;
  localparam logic signed [INT_W-1:0]          LIM_I  = INT_W'(LIM_T);
  localparam logic signed [msp_pkg::DIF_W-1:0] ERR_HI =
    (msp_pkg::DIF_W'(1) <<< (msp_pkg::ERR_W - 1)) - msp_pkg::DIF_W'(1);
  localparam logic signed [msp_pkg::DIF_W-1:0] ERR_LO = -ERR_HI;

  // Configuration registers.
  logic                               enable_r;
  logic signed [msp_pkg::CNT_W-1:0]   tgt_cfg_r;
  logic [msp_pkg::GAIN_W-1:0]         gear_r;
  logic [msp_pkg::GAIN_W-1:0]         kp_r;
  logic [msp_pkg::GAIN_W-1:0]         ki_r;
  logic [msp_pkg::GAIN_W-1:0]         kd_r;
  logic [msp_pkg::GAIN_W-1:0]         ff_r;
  logic [msp_pkg::RPC_W-1:0]          rpc_r;

  // Working registers.
  logic signed [msp_pkg::CNT_W-1:0]   cnt_r;
  logic signed [msp_pkg::PROD_W-1:0]  prod_r;
  logic signed [msp_pkg::MEAS_W-1:0]  meas_r;
  logic signed [msp_pkg::TGT_W-1:0]   tgt_r;
  logic signed [msp_pkg::ERR_W-1:0]   err_r;
  logic signed [msp_pkg::ERR_W-1:0]   prev_r;
  logic signed [msp_pkg::DIFF_W-1:0]  diff_r;
  logic signed [msp_pkg::ACC_W-1:0]   acc_r;
  logic signed [msp_pkg::T_W-1:0]     t_r;
  logic signed [INT_W-1:0]            int_r;
  logic signed [INT_W-1:0]            drv_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [msp_pkg::DUTY_W-1:0]         fwd_r;
  logic [msp_pkg::DUTY_W-1:0]         rev_r;

  logic                               in_fire;
  logic                               out_free;
  logic signed [msp_pkg::CNT_W-1:0]   cnt_sat;
  logic signed [msp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [msp_pkg::GAIN_W:0]    mul_b;
  logic signed [msp_pkg::PROD_W-1:0]  prod;
  logic signed [msp_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [msp_pkg::TGT_W-1:0]   prod_tgt;
  logic signed [msp_pkg::DIF_W-1:0]   err_raw;
  logic signed [msp_pkg::DIF_W-1:0]   err_sat;
  logic signed [msp_pkg::ACC_W-1:0]   acc_rnd;
  logic signed [msp_pkg::T_W-1:0]     t_sat;
  logic signed [INT_W-1:0]            mag;
  logic [DS_W-1:0]                    duty_sum;
  logic [msp_pkg::DUTY_W-1:0]         duty;

  assign in_fire  = in_ready && in_valid;
  assign out_free = !out_valid_r || out_ready;
  assign st       = '{in_valid: in_valid, enable: enable_r, out_free: out_free};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      tgt_cfg_r <= '0;
      gear_r    <= msp_pkg::GEAR_RATIO_RST;
      kp_r      <= msp_pkg::KP_GAIN_RST;
      ki_r      <= msp_pkg::KI_RST;
      kd_r      <= msp_pkg::KD_RST;
      ff_r      <= msp_pkg::FF_GAIN_RST;
      rpc_r     <= msp_pkg::RPC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msp_pkg::CFG_DRIVE_ENABLE:    enable_r  <= cfg_wdata[0];
        msp_pkg::CFG_TARGET_RPM:      tgt_cfg_r <= $signed(cfg_wdata[msp_pkg::CNT_W-1:0]);
        msp_pkg::CFG_GEAR_RATIO:      gear_r    <= cfg_wdata[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_KP_GAIN:         kp_r      <= cfg_wdata[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_KI_TIMES_PERIOD: ki_r      <= cfg_wdata[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_KD_OVER_PERIOD:  kd_r      <= cfg_wdata[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_FF_GAIN:         ff_r      <= cfg_wdata[msp_pkg::GAIN_W-1:0];
        msp_pkg::CFG_RPM_PER_COUNT:   rpc_r     <= cfg_wdata[msp_pkg::RPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (encoder_count > CNT_HI) begin
      cnt_sat = CNT_HI;
    end else if (encoder_count < CNT_LO) begin
      cnt_sat = CNT_LO;
    end else begin
      cnt_sat = encoder_count;
    end
  end

  // Operand select for the shared multiplier: a wide signed operand times a
  // 17-bit signed one. For the speed product the 24-bit scale goes on the
  // wide side so that the narrow side only ever needs 17 bits.
  always_comb begin
    unique case (uw.mul_sel)
      msp_pkg::MUL_CNT_RPC: begin
        mul_a = msp_pkg::MUL_A_W'($signed({1'b0, rpc_r}));
        mul_b = $signed({cnt_r[msp_pkg::CNT_W-1], cnt_r});
      end
      msp_pkg::MUL_TGT_GEAR: begin
        mul_a = msp_pkg::MUL_A_W'(tgt_cfg_r);
        mul_b = $signed({1'b0, gear_r});
      end
      msp_pkg::MUL_KI_ERR: begin
        mul_a = msp_pkg::MUL_A_W'(err_r);
        mul_b = $signed({1'b0, ki_r});
      end
      msp_pkg::MUL_FF_TGT: begin
        mul_a = msp_pkg::MUL_A_W'(tgt_r);
        mul_b = $signed({1'b0, ff_r});
      end
      msp_pkg::MUL_KP_ERR: begin
        mul_a = msp_pkg::MUL_A_W'(err_r);
        mul_b = $signed({1'b0, kp_r});
      end
      msp_pkg::MUL_KD_DIFF: begin
        mul_a = diff_r;
        mul_b = $signed({1'b0, kd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Rounding to Q16 is add half then arithmetic shift (floor).
  assign prod_rnd = prod_r + msp_pkg::PROD_W'(32768);
  assign acc_rnd  = acc_r + msp_pkg::ACC_W'(32768);
  assign prod_tgt = $signed(prod_r[msp_pkg::TGT_W-1:0]);
  assign err_raw  = msp_pkg::DIF_W'(prod_tgt) - msp_pkg::DIF_W'(meas_r);

  always_comb begin
    if (err_raw > ERR_HI) begin
      err_sat = ERR_HI;
    end else if (err_raw < ERR_LO) begin
      err_sat = ERR_LO;
    end else begin
      err_sat = err_raw;
    end
    if (t_r > LIM_T) begin
      t_sat = LIM_T;
    end else if (t_r < NLIM_T) begin
      t_sat = NLIM_T;
    end else begin
      t_sat = t_r;
    end
  end

  assign mag      = (drv_r < 0) ? -drv_r : drv_r;
  assign duty_sum = DS_W'($unsigned(mag)) + DS_W'(32768);
  assign duty     = duty_sum[16 +: msp_pkg::DUTY_W];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cnt_r <= cnt_sat;
    end
    if (uw.mul_sel != msp_pkg::MUL_NONE) begin
      prod_r <= prod;
    end
    case (uw.acc_op)
      msp_pkg::ACC_LOAD: acc_r <= msp_pkg::ACC_W'(prod_r);
      msp_pkg::ACC_ADD:  acc_r <= acc_r + msp_pkg::ACC_W'(prod_r);
      default: ;
    endcase
    case (uw.reg_op)
      msp_pkg::OP_MEAS: meas_r <= $signed(prod_r[msp_pkg::MEAS_W-1:0]);
      msp_pkg::OP_ERR: begin
        tgt_r <= prod_tgt;
        err_r <= msp_pkg::ERR_W'(err_sat);
      end
      msp_pkg::OP_DIFF: diff_r <= msp_pkg::DIFF_W'(err_r) - msp_pkg::DIFF_W'(prev_r);
      msp_pkg::OP_INT_ADD: begin
        t_r <= msp_pkg::T_W'(prod_rnd >>> 16) + msp_pkg::T_W'(int_r);
      end
      msp_pkg::OP_DRV_SUM: begin
        t_r <= msp_pkg::T_W'(acc_rnd >>> 16) + msp_pkg::T_W'(int_r);
      end
      msp_pkg::OP_DRV_SAT: drv_r <= INT_W'(t_sat);
      msp_pkg::OP_CLEAR:   drv_r <= '0;
      default: ;
    endcase
    if ((uw.reg_op == msp_pkg::OP_OUTPUT) && out_free) begin
      // Zero drive counts as forward; both duties are then zero anyway.
      fwd_r <= (drv_r < 0) ? '0 : duty;
      rev_r <= (drv_r < 0) ? duty : '0;
    end
  end

  // Loop state that the controller keeps from tick to tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r  <= '0;
      prev_r <= '0;
    end else begin
      case (uw.reg_op)
        msp_pkg::OP_DIFF:    prev_r <= err_r;
        msp_pkg::OP_INT_SAT: int_r  <= INT_W'(t_sat);
        msp_pkg::OP_CLEAR: begin
          int_r  <= '0;
          prev_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((uw.reg_op == msp_pkg::OP_OUTPUT) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign duty_forward = fwd_r;
  assign duty_reverse = rev_r;

  `MSP_ASSERT_IMPL(a_one_bridge_side, out_valid_r, (fwd_r == '0) || (rev_r == '0), "both bridge duties are nonzero")
  `MSP_ASSERT_COND(a_integral_bound, (int_r <= LIM_I) && (int_r >= -LIM_I), "integral left its clamp range")
  `MSP_ASSERT_NEXT(a_result_held, (uw.reg_op == msp_pkg::OP_OUTPUT) && !out_free, $stable(fwd_r) && $stable(rev_r), "pending result was overwritten")

endmodule

// ----- design/motor_speed_pi_feedforward_core.sv -----
// Top level of the motor speed controller with feedforward.
// Depends on msp_pkg, msp_if, msp_sequencer and msp_datapath.
//
// One encoder tick beat in gives one duty beat out. With the drive enabled
// the program steps through six products on a single shared 39 x 17
// multiplier, the integral and drive clamps, and the output step. With the
// drive disabled a tick clears the integral, the previous error and the
// drive, then goes to the output step. The finished duties wait in an
// output register, so the next beat is taken while a result is still
// pending; the program only holds at its output step when that register is
// still full. There is no clearing pass after reset.
// Configuration writes are applied at once and are meant to be issued
// while no tick is in flight.
module motor_speed_pi_feedforward_core #(
  parameter int DUTY_MAX    = 1023,
  parameter int COUNT_LIMIT = 30000
) (
  input  logic                            clk,
  input  logic                            rst_n,
  msp_in_if.sink                          in_ch,
  msp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  msp_pkg::uword_t  uw;
  msp_pkg::status_t st;
  logic             in_ready;

  msp_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .uw       (uw),
    .in_ready (in_ready)
  );

  msp_datapath #(
    .DUTY_MAX    (DUTY_MAX),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .uw            (uw),
    .in_ready      (in_ready),
    .in_valid      (in_ch.valid),
    .encoder_count (in_ch.encoder_count),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .duty_forward  (out_ch.duty_forward),
    .duty_reverse  (out_ch.duty_reverse),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .st            (st)
  );

  assign in_ch.ready = in_ready;

endmodule
